// ===== hw/rtl/cbf_pkg.sv =====
// Shared types and constants for the calibrated blink and fade controller.
// Used by cbf_divider and calibrated_blink_fade_controller; depends on nothing.
`default_nettype none

package cbf_pkg;

  // Field widths.
  localparam int SAMPLE_BITS = 10;
  localparam int TIME_BITS   = 32;
  localparam int CFG_W       = 16;
  localparam int DUTY_W      = 8;

  // Widths of the linear map datapath.
  localparam int DIFF_W = SAMPLE_BITS + 1;   // signed sample minus range bound
  localparam int SPAN_W = CFG_W + 1;         // signed interval span
  localparam int PROD_W = DIFF_W + SPAN_W;   // signed product
  localparam int MAG_W  = PROD_W - 1;        // product magnitude, divider width
  localparam int QUOT_W = MAG_W + 1;         // signed quotient
  localparam int SUM_W  = MAG_W + 2;         // quotient plus interval_min
  localparam int CNT_W  = $clog2(MAG_W + 1);

  // Configuration port.
  localparam int                 IDX_W       = 2;
  localparam logic [IDX_W-1:0]   CFG_IDX_MIN = 2'd0;
  localparam logic [IDX_W-1:0]   CFG_IDX_MAX = 2'd1;
  localparam logic [CFG_W-1:0]   INTERVAL_MIN_RST = 16'd50;
  localparam logic [CFG_W-1:0]   INTERVAL_MAX_RST = 16'd4000;

  // Calibration range reset values.
  localparam logic [SAMPLE_BITS-1:0] RANGE_LOW_RST  = SAMPLE_BITS'(1023);
  localparam logic [SAMPLE_BITS-1:0] RANGE_HIGH_RST = SAMPLE_BITS'(10);

  // Fade interval is the blink interval divided by 100, done as a multiply by
  // ceil(2^23 / 100) and a shift; exact for every 16-bit interval.
  localparam int                 FADE_RECIP_W = 17;
  localparam logic [FADE_RECIP_W-1:0] FADE_RECIP = 17'd83887;
  localparam int                 FADE_SHIFT   = 23;
  localparam int                 FADE_PROD_W  = CFG_W + FADE_RECIP_W;

  localparam logic [DUTY_W-1:0]  DUTY_MAX = 8'd255;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL,
    ST_MUL,
    ST_DSTART,
    ST_DWAIT,
    ST_SUM,
    ST_SCALE,
    ST_STEP,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cbf_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on cbf_pkg for widths and the status struct.
`default_nettype none

module cbf_divider (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [cbf_pkg::MAG_W-1:0]       dividend,
  input  wire logic [cbf_pkg::SAMPLE_BITS-1:0] divisor,
  output cbf_pkg::div_status_t               status,
  output logic      [cbf_pkg::MAG_W-1:0]       quotient
);
  import cbf_pkg::*;

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [SAMPLE_BITS-1:0] rem_r;
  logic [SAMPLE_BITS-1:0] den_r;
  logic [MAG_W-1:0]       quo_r;
  logic [SAMPLE_BITS:0]   trial;
  logic                   fits;

  // The remainder stays below the divisor, so the shifted trial value fits
  // one bit more than the divisor.
  assign trial = {rem_r, quo_r[MAG_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(MAG_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[MAG_W-2:0], fits};
      if (fits) begin
        rem_r <= SAMPLE_BITS'(trial - {1'b0, den_r});
      end else begin
        rem_r <= trial[SAMPLE_BITS-1:0];
      end
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/calibrated_blink_fade_controller.sv =====
// Top level of the calibrated blink and fade controller: sequencer, map
// datapath, timers and the result register. Depends on cbf_pkg and cbf_divider.
//
//   channel  signals                                   direction  role
//   in_      valid/ready, switch_on, pot_sample, now   input      one control pass
//   out_     valid/ready, duties, lights, flags        output     one result per pass
//   cfg_     we, index, wdata                          input      interval limits
//
// A calibrating pass (switch off) goes from ST_CAL to ST_OUT. A running pass
// goes through ST_MUL, ST_DSTART, ST_DWAIT, ST_SUM, ST_SCALE and ST_STEP to
// ST_OUT, waiting in ST_DWAIT on the divider, which resolves one quotient bit
// per cycle over MAG_W bits; an empty calibrated range skips the divider. ST_OUT
// loads the result once its register is free; in_ready returns on the cycle after the load.
// Reset is synchronous and active low; it clears the sequencer, the limits
// and all calibration, fade and blink state. No clearing pass is needed.
// The result sits in its own register, so a new transaction is accepted
// while the previous result still waits for out_ready.
`default_nettype none

module calibrated_blink_fade_controller (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel.
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_switch_on,
  input  wire logic [cbf_pkg::SAMPLE_BITS-1:0] in_pot_sample,
  input  wire logic [cbf_pkg::TIME_BITS-1:0]   in_now_ms,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [cbf_pkg::DUTY_W-1:0]      out_led_a_duty,
  output logic      [cbf_pkg::DUTY_W-1:0]      out_led_b_duty,
  output logic                               out_lights_a,
  output logic                               out_lights_b,
  output logic                               out_calibrating,
  output logic      [cbf_pkg::CFG_W-1:0]       out_blink_interval,
  // Configuration port.
  input  wire logic                          cfg_we,
  input  wire logic [cbf_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [cbf_pkg::CFG_W-1:0]       cfg_wdata
);
  import cbf_pkg::*;

  // Sequencer.
  ctl_state_t state_r, state_nxt;
  logic       accept;
  logic       out_free;
  logic       out_load;
  logic       div_start;

  // Configuration registers.
  logic [CFG_W-1:0] imin_r;
  logic [CFG_W-1:0] imax_r;

  // Latched transaction.
  logic                   sw_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [TIME_BITS-1:0]   now_r;

  // Persistent controller state.
  logic [SAMPLE_BITS-1:0] range_low_r;
  logic [SAMPLE_BITS-1:0] range_high_r;
  logic [DUTY_W-1:0]      fade_level_r;
  logic                   fade_down_r;
  logic                   toggle_phase_r;
  logic [TIME_BITS-1:0]   last_fade_r;
  logic [TIME_BITS-1:0]   last_blink_r;
  logic [DUTY_W-1:0]      held_led_a_r;
  logic [DUTY_W-1:0]      held_led_b_r;
  logic                   held_lights_a_r;
  logic                   held_lights_b_r;

  // Map datapath.
  logic signed [DIFF_W-1:0] diff_w;
  logic signed [SPAN_W-1:0] span_w;
  logic signed [PROD_W-1:0] prod_w;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DIFF_W-1:0] den_w;
  logic signed [DIFF_W-1:0] den_r;
  logic signed [PROD_W-1:0] prod_abs;
  logic signed [DIFF_W-1:0] den_abs;
  logic                     quot_neg_r;
  logic signed [QUOT_W-1:0] quot_mag_s;
  logic signed [QUOT_W-1:0] quot_r;
  logic signed [SUM_W-1:0]  mapped;
  logic signed [SUM_W-1:0]  omin_s;
  logic signed [SUM_W-1:0]  omax_s;
  logic [CFG_W-1:0]         clamped;
  logic [CFG_W-1:0]         interval_r;
  logic [FADE_PROD_W-1:0]   fade_prod;
  logic [CFG_W-1:0]         fade_int_r;

  // Timer and fade step.
  logic [TIME_BITS-1:0] fade_elapsed;
  logic [TIME_BITS-1:0] blink_elapsed;
  logic [DUTY_W-1:0]    fade_next;

  // Divider link.
  div_status_t      div_stat;
  logic [MAG_W-1:0] div_quot;

  // Result register.
  logic              out_valid_r;
  logic [DUTY_W-1:0] out_led_a_r;
  logic [DUTY_W-1:0] out_led_b_r;
  logic              out_lights_a_r;
  logic              out_lights_b_r;
  logic              out_cal_r;
  logic [CFG_W-1:0]  out_interval_r;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // ------------------------------------------------------------------------
  // Sequencer: next state and strobes.
  // ------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_switch_on ? ST_MUL : ST_CAL;
        end
      end
      ST_CAL: begin
        state_nxt = ST_OUT;
      end
      ST_MUL: begin
        // An empty calibrated range maps straight to interval_min.
        state_nxt = (range_high_r == range_low_r) ? ST_SUM : ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ------------------------------------------------------------------------
  // Configuration registers. Indexes past the two limits are ignored.
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imin_r <= INTERVAL_MIN_RST;
      imax_r <= INTERVAL_MAX_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_MIN) begin
        imin_r <= cfg_wdata;
      end
      if (cfg_index == CFG_IDX_MAX) begin
        imax_r <= cfg_wdata;
      end
    end
  end

  // Input latch.
  always_ff @(posedge clk) begin
    if (accept) begin
      sw_r     <= in_switch_on;
      sample_r <= in_pot_sample;
      now_r    <= in_now_ms;
    end
  end

  // ------------------------------------------------------------------------
  // Linear map: (sample - low) * (max - min) / (high - low) + min, with the
  // division truncating toward zero. The product is registered before the
  // divider sees it; the divider works on magnitudes and the sign is put
  // back on the quotient.
  // ------------------------------------------------------------------------
  assign diff_w = $signed({1'b0, sample_r}) - $signed({1'b0, range_low_r});
  assign span_w = $signed({1'b0, imax_r}) - $signed({1'b0, imin_r});
  assign prod_w = diff_w * span_w;
  assign den_w  = $signed({1'b0, range_high_r}) - $signed({1'b0, range_low_r});

  assign prod_abs = prod_r[PROD_W-1] ? -prod_r : prod_r;
  assign den_abs  = den_r[DIFF_W-1] ? -den_r : den_r;

  assign quot_mag_s = $signed({1'b0, div_quot});

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_r <= prod_w;
      den_r  <= den_w;
    end
    if (state_r == ST_DSTART) begin
      quot_neg_r <= prod_r[PROD_W-1] ^ den_r[DIFF_W-1];
    end
    if (state_r == ST_MUL) begin
      quot_r <= '0;
    end else if (state_r == ST_DWAIT && div_stat.done) begin
      quot_r <= quot_neg_r ? -quot_mag_s : quot_mag_s;
    end
  end

  cbf_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_abs[MAG_W-1:0]),
    .divisor  (den_abs[SAMPLE_BITS-1:0]),
    .status   (div_stat),
    .quotient (div_quot)
  );

  // Clamp: the lower bound wins when the limits are crossed.
  assign mapped = SUM_W'(quot_r) + $signed(SUM_W'(imin_r));
  assign omin_s = $signed(SUM_W'(imin_r));
  assign omax_s = $signed(SUM_W'(imax_r));

  always_comb begin
    priority if (mapped < omin_s) begin
      clamped = imin_r;
    end else if (mapped > omax_s) begin
      clamped = imax_r;
    end else begin
      clamped = mapped[CFG_W-1:0];
    end
  end

  // Fade interval is one hundredth of the blink interval, rounded down.
  assign fade_prod = FADE_PROD_W'(interval_r) * FADE_PROD_W'(FADE_RECIP);

  always_ff @(posedge clk) begin
    if (state_r == ST_CAL) begin
      interval_r <= '0;
    end else if (state_r == ST_SUM) begin
      interval_r <= clamped;
    end
    if (state_r == ST_SCALE) begin
      fade_int_r <= CFG_W'(fade_prod[FADE_PROD_W-1:FADE_SHIFT]);
    end
  end

  // ------------------------------------------------------------------------
  // Timers, fade triangle, blink phase and calibration range.
  // ------------------------------------------------------------------------
  assign fade_elapsed  = now_r - last_fade_r;
  assign blink_elapsed = now_r - last_blink_r;
  assign fade_next     = fade_down_r ? (fade_level_r - 1'b1) : (fade_level_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r     <= RANGE_LOW_RST;
      range_high_r    <= RANGE_HIGH_RST;
      fade_level_r    <= '0;
      fade_down_r     <= 1'b0;
      toggle_phase_r  <= 1'b0;
      last_fade_r     <= '0;
      last_blink_r    <= '0;
      held_led_a_r    <= '0;
      held_led_b_r    <= '0;
      held_lights_a_r <= 1'b0;
      held_lights_b_r <= 1'b0;
    end else if (state_r == ST_CAL) begin
      held_led_a_r    <= '0;
      held_led_b_r    <= '0;
      held_lights_a_r <= 1'b0;
      held_lights_b_r <= 1'b0;
      if (sample_r > range_high_r) begin
        range_high_r <= sample_r;
      end
      if (sample_r < range_low_r) begin
        range_low_r <= sample_r;
      end
    end else if (state_r == ST_STEP) begin
      if (fade_elapsed > TIME_BITS'(fade_int_r)) begin
        last_fade_r  <= now_r;
        held_led_a_r <= fade_level_r;
        held_led_b_r <= DUTY_MAX - fade_level_r;
        fade_level_r <= fade_next;
        // The direction turns whenever the level reaches either end.
        if (fade_next == '0 || fade_next == DUTY_MAX) begin
          fade_down_r <= !fade_down_r;
        end
      end
      if (blink_elapsed > TIME_BITS'(interval_r)) begin
        last_blink_r    <= now_r;
        held_lights_a_r <= toggle_phase_r;
        held_lights_b_r <= !toggle_phase_r;
        toggle_phase_r  <= !toggle_phase_r;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result register.
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_led_a_r    <= held_led_a_r;
      out_led_b_r    <= held_led_b_r;
      out_lights_a_r <= held_lights_a_r;
      out_lights_b_r <= held_lights_b_r;
      out_cal_r      <= !sw_r;
      out_interval_r <= interval_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_led_a_duty     = out_led_a_r;
  assign out_led_b_duty     = out_led_b_r;
  assign out_lights_a       = out_lights_a_r;
  assign out_lights_b       = out_lights_b_r;
  assign out_calibrating    = out_cal_r;
  assign out_blink_interval = out_interval_r;

  // ------------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------------
`ifndef SYNTH
  // Once a transaction is taken, the sequencer is busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input taken again right after a transaction");

  // The divider only reports completion while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DWAIT))
    else $error("divider finished outside its wait state");

  // A calibrating result carries all outputs blanked and a zero interval.
  a_cal_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_calibrating) |->
      (out_blink_interval == '0 && out_led_a_duty == '0 && out_led_b_duty == '0 &&
       !out_lights_a && !out_lights_b))
    else $error("calibrating result is not blanked");
`endif

endmodule

`default_nettype wire

// ===== test/tb_calibrated_blink_fade_controller.sv =====
// Testbench for calibrated_blink_fade_controller: directed and random control passes,
// checked against an in-bench model of calibration, interval mapping, fade and blink.
// Depends on cbf_pkg and the controller RTL only.
`timescale 1ns / 100ps

module tb_calibrated_blink_fade_controller;
  import cbf_pkg::*;

  // The two upper register indexes decode to nothing; writes there must be ignored.
  localparam logic [IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;
  // The watchdog allows many times the slowest expected run of roughly 1650
  // transactions with heavy idling.
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 40;

  // One result transaction, field for field.
  typedef struct packed {
    logic [DUTY_W-1:0] led_a;
    logic [DUTY_W-1:0] led_b;
    logic              lights_a;
    logic              lights_b;
    logic              calibrating;
    logic [CFG_W-1:0]  interval;
  } pass_out_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_switch_on = 1'b0;
  logic [SAMPLE_BITS-1:0] in_pot_sample = '0;
  logic [TIME_BITS-1:0]   in_now_ms = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [DUTY_W-1:0]      out_led_a_duty;
  logic [DUTY_W-1:0]      out_led_b_duty;
  logic                   out_lights_a;
  logic                   out_lights_b;
  logic                   out_calibrating;
  logic [CFG_W-1:0]       out_blink_interval;
  logic                   cfg_we = 1'b0;
  logic [IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  calibrated_blink_fade_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_switch_on       (in_switch_on),
    .in_pot_sample      (in_pot_sample),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_led_a_duty     (out_led_a_duty),
    .out_led_b_duty     (out_led_b_duty),
    .out_lights_a       (out_lights_a),
    .out_lights_b       (out_lights_b),
    .out_calibrating    (out_calibrating),
    .out_blink_interval (out_blink_interval),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Controller model. It mirrors the block's architectural state and is
  // advanced once for every input transaction, at the edge that accepts it.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]       lim_min, lim_max;       // interval limits
  logic [SAMPLE_BITS-1:0] cal_low, cal_high;      // calibrated pot range
  logic [DUTY_W-1:0]      fade_lvl;               // triangle position
  logic                   fading_down;
  logic                   blink_phase;
  logic [TIME_BITS-1:0]   fade_stamp, blink_stamp;
  logic [DUTY_W-1:0]      duty_a, duty_b;         // held LED duties
  logic                   string_a, string_b;     // held light levels

  pass_out_t awaited_outputs[$];

  // Bookkeeping for the summary and the verdict.
  int unsigned mismatch_count = 0;
  int unsigned passes_sent    = 0;
  int unsigned results_seen   = 0;
  int unsigned cal_passes     = 0;
  int unsigned fade_steps     = 0;
  int unsigned blink_toggles  = 0;
  int unsigned limit_settings = 0;
  int unsigned cycle_count    = 0;

  // Stimulus knobs: percent of cycles the sender idles and the receiver stalls.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  // Millisecond time of the most recent pass; the random time base walks from here.
  logic [TIME_BITS-1:0] wall_ms = '0;

  function automatic void reset_model();
    lim_min     = INTERVAL_MIN_RST;
    lim_max     = INTERVAL_MAX_RST;
    cal_low     = RANGE_LOW_RST;
    cal_high    = RANGE_HIGH_RST;
    fade_lvl    = '0;
    fading_down = 1'b0;
    blink_phase = 1'b0;
    fade_stamp  = '0;
    blink_stamp = '0;
    duty_a      = '0;
    duty_b      = '0;
    string_a    = 1'b0;
    string_b    = 1'b0;
  endfunction

  function automatic void write_limit(input logic [IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] value);
    if (idx == CFG_IDX_MIN) begin
      lim_min = value;
    end else if (idx == CFG_IDX_MAX) begin
      lim_max = value;
    end
  endfunction

  // Linear map of the sample from the calibrated range onto the limits. The
  // arithmetic is signed 64-bit so an inverted range or inverted limits run
  // backwards exactly as the block does; division truncates toward zero. The
  // clamp tests the lower limit first, which settles inverted limits.
  function automatic logic [CFG_W-1:0] map_interval(input logic [SAMPLE_BITS-1:0] s);
    longint sv, lo, hi, mn, mx, m;
    sv = s;
    lo = cal_low;
    hi = cal_high;
    mn = lim_min;
    mx = lim_max;
    if (hi == lo) begin
      m = mn;
    end else begin
      m = (sv - lo) * (mx - mn) / (hi - lo) + mn;
    end
    if (m < mn) begin
      m = mn;
    end else if (m > mx) begin
      m = mx;
    end
    return m[CFG_W-1:0];
  endfunction

  // One control pass: returns the result it must produce and moves the state.
  function automatic pass_out_t run_control_pass(input logic on,
                                                 input logic [SAMPLE_BITS-1:0] s,
                                                 input logic [TIME_BITS-1:0] t);
    pass_out_t            r;
    logic [CFG_W-1:0]     iv;
    logic [TIME_BITS-1:0] since;
    iv = '0;
    if (on) begin
      iv = map_interval(s);
      // Fade runs at one hundredth of the blink interval. Elapsed time wraps,
      // and a step needs the elapsed time to strictly exceed the interval.
      since = t - fade_stamp;
      if (since > iv / 100) begin
        fade_stamp = t;
        duty_a     = fade_lvl;
        duty_b     = DUTY_MAX - fade_lvl;
        fade_lvl   = fading_down ? fade_lvl - 8'd1 : fade_lvl + 8'd1;
        // The triangle turns whenever it lands on either end.
        if (fade_lvl == '0 || fade_lvl == DUTY_MAX) begin
          fading_down = !fading_down;
        end
        fade_steps++;
      end
      since = t - blink_stamp;
      if (since > iv) begin
        blink_stamp = t;
        string_a    = blink_phase;
        blink_phase = !blink_phase;
        string_b    = blink_phase;
        blink_toggles++;
      end
    end else begin
      // Calibrating: blank everything and widen the range; timers keep still.
      duty_a   = '0;
      duty_b   = '0;
      string_a = 1'b0;
      string_b = 1'b0;
      if (s > cal_high) begin
        cal_high = s;
      end
      if (s < cal_low) begin
        cal_low = s;
      end
      cal_passes++;
    end
    r.led_a       = duty_a;
    r.led_b       = duty_b;
    r.lights_a    = string_a;
    r.lights_b    = string_b;
    r.calibrating = !on;
    r.interval    = iv;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the in-order comparison.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    pass_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_outputs.size() == 0) begin
        $display("%0t ns: result with no pass outstanding, expected none, got %0d %0d %0b %0b %0b %0d",
                 $time, out_led_a_duty, out_led_b_duty, out_lights_a, out_lights_b,
                 out_calibrating, out_blink_interval);
        mismatch_count++;
      end else begin
        want = awaited_outputs.pop_front();
        compare_field("led_a_duty", want.led_a, out_led_a_duty);
        compare_field("led_b_duty", want.led_b, out_led_b_duty);
        compare_field("lights_a", want.lights_a, out_lights_a);
        compare_field("lights_b", want.lights_b, out_lights_b);
        compare_field("calibrating", want.calibrating, out_calibrating);
        compare_field("blink_interval", want.interval, out_blink_interval);
        results_seen++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: watchdog after %0d cycles, %0d results still awaited",
               $time, CYCLE_LIMIT, awaited_outputs.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Offers one pass and returns at the edge that accepts it. Valid is left high
  // afterwards: the next call either replaces the payload in this same step or
  // lowers valid for an idle gap, and drain_passes lowers it otherwise, so valid
  // never gets two assignments in one step.
  task automatic send_pass(input logic on, input logic [SAMPLE_BITS-1:0] s,
                           input logic [TIME_BITS-1:0] t);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_switch_on  <= on;
    in_pot_sample <= s;
    in_now_ms     <= t;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    awaited_outputs.push_back(run_control_pass(on, s, t));
    wall_ms = t;
    passes_sent++;
  endtask

  // Holds the sender off until every outstanding result has been checked.
  task automatic drain_passes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_outputs.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes both limits on an idle block, optionally touching the two unused
  // indexes as well, which must leave the limits alone.
  task automatic program_limits(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                input bit spare);
    drain_passes();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_MIN;
    cfg_wdata <= lo;
    @(posedge clk);
    write_limit(CFG_IDX_MIN, lo);
    cfg_index <= CFG_IDX_MAX;
    cfg_wdata <= hi;
    @(posedge clk);
    write_limit(CFG_IDX_MAX, hi);
    if (spare) begin
      cfg_index <= CFG_IDX_SPARE_LO;
      cfg_wdata <= CFG_W'($urandom);
      @(posedge clk);
      cfg_index <= CFG_IDX_SPARE_HI;
      cfg_wdata <= CFG_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    limit_settings++;
  endtask

  task automatic program_random_limits();
    logic [CFG_W-1:0] lo, hi;
    case ($urandom_range(6))
      0: begin
        lo = INTERVAL_MIN_RST;
        hi = INTERVAL_MAX_RST;
      end
      1: begin
        lo = '0;
        hi = '1;
      end
      2: begin  // fast blinking, fade every pass or two
        lo = CFG_W'($urandom_range(20));
        hi = CFG_W'($urandom_range(600, 20));
      end
      3: begin  // inverted limits
        lo = CFG_W'($urandom_range(30000, 1000));
        hi = CFG_W'($urandom_range(999));
      end
      4: begin
        lo = CFG_W'($urandom_range(300));
        hi = lo;
      end
      5: begin
        lo = CFG_W'($urandom);
        hi = CFG_W'($urandom);
      end
      default: begin
        lo = CFG_W'($urandom_range(200));
        hi = CFG_W'($urandom_range(5000, 200));
      end
    endcase
    program_limits(lo, hi, $urandom_range(1));
  endtask

  // Picks the next pass time. Most passes move time forward by a fraction of
  // the fade or blink interval; some land exactly on or one past a timer
  // threshold, some repeat the last time and a few jump anywhere, which also
  // exercises wrap-around of the elapsed-time arithmetic.
  function automatic logic [TIME_BITS-1:0] next_stamp(input logic [CFG_W-1:0] iv);
    logic [TIME_BITS-1:0] t;
    case ($urandom_range(9))
      0:       t = blink_stamp + iv + $urandom_range(1);
      1:       t = fade_stamp + iv / 100 + $urandom_range(1);
      2:       t = $urandom;
      3:       t = wall_ms;
      4, 5:    t = wall_ms + $urandom_range(iv + 1);
      default: t = wall_ms + $urandom_range(iv / 50 + 2);
    endcase
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Out of reset the calibrated range is inverted (low 1023, high 10), so the
  // map runs backwards until the first calibrating pass.
  task automatic test_inverted_range();
    send_pass(1'b1, 10'd0, 32'd0);
    send_pass(1'b1, 10'd1023, 32'd1);
    send_pass(1'b1, 10'd600, 32'd3000);
    send_pass(1'b1, 10'd10, wall_ms + 32'd5000);
  endtask

  // A single calibrating sample collapses the range to one point, so every
  // running pass maps to the lower limit.
  task automatic test_empty_range();
    send_pass(1'b0, 10'd500, wall_ms + 32'd7);
    send_pass(1'b1, 10'd0, wall_ms + 32'd60);
    send_pass(1'b1, 10'd1023, wall_ms + 32'd1);
    send_pass(1'b1, 10'd500, wall_ms + 32'd51);
  endtask

  // With the range still empty the interval is the lower limit, 100 ms here,
  // and the fade interval is 1 ms. Each timer is hit exactly at its threshold
  // and one past it, then time wraps through zero.
  task automatic test_timer_edges();
    program_limits(16'd100, 16'd200, 1'b0);
    send_pass(1'b1, 10'd300, blink_stamp + 32'd100);
    send_pass(1'b1, 10'd300, blink_stamp + 32'd101);
    send_pass(1'b1, 10'd300, fade_stamp + 32'd1);
    send_pass(1'b1, 10'd300, fade_stamp + 32'd2);
    send_pass(1'b1, 10'd300, 32'hFFFF_FFF0);
    send_pass(1'b1, 10'd300, 32'h0000_0010);
    send_pass(1'b1, 10'd300, 32'h0000_0100);
  endtask

  // Full calibration with the extreme samples, then the extreme limit settings:
  // zero interval, full 16-bit span, inverted limits, and back to reset values.
  task automatic test_limit_extremes();
    send_pass(1'b0, 10'd0, wall_ms + 32'd3);
    send_pass(1'b0, 10'd1023, wall_ms + 32'd3);
    program_limits(16'd0, 16'd0, 1'b1);
    send_pass(1'b1, 10'd1023, wall_ms);
    send_pass(1'b1, 10'd0, wall_ms + 32'd1);
    program_limits(16'd0, 16'hFFFF, 1'b1);
    send_pass(1'b1, 10'd1023, wall_ms + 32'd700);
    send_pass(1'b1, 10'd0, wall_ms + 32'd1);
    send_pass(1'b1, 10'd512, 32'hFFFF_FFFF);
    program_limits(16'hFFFF, 16'd0, 1'b0);
    send_pass(1'b1, 10'd300, wall_ms + 32'd2000);
    program_limits(INTERVAL_MIN_RST, INTERVAL_MAX_RST, 1'b1);
    send_pass(1'b1, 10'd700, wall_ms + 32'd5000);
  endtask

  // Random passes under one idling pattern. The limits change at the start and
  // again halfway; each change first holds the sender until every result is in.
  task automatic test_random_passes(input int unsigned count, input int unsigned idle,
                                    input int unsigned stall);
    logic [SAMPLE_BITS-1:0] s;
    logic [CFG_W-1:0]       iv;
    idle_pct  = idle;
    stall_pct = stall;
    program_random_limits();
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        program_random_limits();
      end
      if ($urandom_range(99) < 8) begin
        case ($urandom_range(5))
          0:       s = '0;
          1:       s = '1;
          default: s = SAMPLE_BITS'($urandom);
        endcase
        send_pass(1'b0, s, wall_ms + $urandom_range(50));
      end else begin
        case ($urandom_range(7))
          0:       s = '0;
          1:       s = '1;
          2:       s = cal_low;
          3:       s = cal_high;
          default: s = SAMPLE_BITS'($urandom);
        endcase
        iv = map_interval(s);
        send_pass(1'b1, s, next_stamp(iv));
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_inverted_range();
    test_empty_range();
    test_timer_edges();
    test_limit_extremes();
    test_random_passes(400, 0, 0);
    test_random_passes(400, 51, 0);
    test_random_passes(400, 0, 51);
    test_random_passes(400, 34, 34);

    drain_passes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_outputs.size() != 0) begin
      $display("%0t ns: results left outstanding, expected 0, got %0d",
               $time, awaited_outputs.size());
      mismatch_count++;
    end

    $display("Sent %0d control passes (%0d calibrating) over %0d limit settings; %0d results checked.",
             passes_sent, cal_passes, limit_settings, results_seen);
    $display("Model saw %0d fade steps and %0d blink toggles; %0d mismatches.",
             fade_steps, blink_toggles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
